// ----- sv/histogram_equalizer_8bit_assert.svh -----
// assertion macros for the histogram equalizer
`ifndef HISTOGRAM_EQUALIZER_8BIT_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_8BIT_ASSERT_SVH
`define HEQ_ASSERT_IMPL(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define HEQ_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- sv/heq_pkg.sv -----
// shared constants and types for the histogram equalizer
package heq_pkg;
  localparam int CountWidth = 32;
  localparam int NumBins = 256;
  localparam int BinWidth = 8;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [BinWidth-1:0] bin_t;
  typedef enum logic {REQ_ACCUM = 1'b0, REQ_MAP = 1'b1} req_t;
  localparam count_t CountMax = '1;
endpackage

// ----- sv/heq_divider.sv -----
// restoring divider for the table entry quotient, one bit per cycle
module heq_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [heq_pkg::CountWidth+9:0] num,
  input  logic [heq_pkg::CountWidth+9:0] den,
  output logic done,
  output logic [8:0] quot
);
  import heq_pkg::*;
  localparam int W = CountWidth + 10;
  logic [W-1:0] rem;
  logic [W-1:0] dsr;
  logic [W-1:0] numr;
  logic [$clog2(W+1)-1:0] cnt;
  logic busy;
  logic [W:0] trial;
  logic [W-1:0] quo;

  assign trial = {rem, numr[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        rem <= '0;
        numr <= num;
        dsr <= den;
        cnt <= W[$clog2(W+1)-1:0];
        quo <= '0;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], numr[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        numr <= {numr[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == 1) busy <= 1'b0;
        done <= (cnt == 1);
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quot = (quo > W'(255)) ? 9'd255 : quo[8:0];
endmodule

// ----- sv/histogram_equalizer_8bit.sv -----
// histogram equalizer top level: histogram, table build sequencer and map lookup
// accumulate item without last: read, write back; map item: read, output until m_tready
// last accumulate item: a summing pass, then a table build with the serial divider,
// then a clear sweep of the histogram memory
// after reset a pass clears the histogram and sets an identity table, s_tready low
// throughput: one item in flight at a time
module histogram_equalizer_8bit (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata, // pixel_value
  input  logic s_tuser, // req_type
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata, // equalized_pixel
  output logic m_tlast
);
  import heq_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ACC_RD, ST_ACC_WR, ST_MAP_RD, ST_OUT,
    ST_SUM_RD, ST_SUM, ST_BLD_RD, ST_BLD_CALC, ST_BLD_DIV, ST_WIPE
  } state_t;

  state_t state;
  count_t hist [NumBins];
  bin_t lut [NumBins];
  count_t hist_q;
  bin_t lut_q;
  count_t total;
  count_t minv;
  logic [CountWidth+7:0] acc;
  logic found;
  logic ident;
  bin_t idx;
  logic last_q;
  bin_t px;
  logic div_start;
  logic div_done;
  logic [8:0] div_q;
  logic [CountWidth+9:0] div_num;
  logic [CountWidth+9:0] div_den;
  logic [CountWidth+7:0] nval;
  logic [CountWidth+7:0] dval;
  logic [CountWidth+7:0] acc_sum;

  assign acc_sum = acc + {8'd0, hist_q};
  assign nval = (acc_sum > {8'd0, minv}) ? acc_sum - {8'd0, minv} : '0;
  assign dval = {8'd0, total - minv};
  assign div_num = {2'b0, nval} * 10'd510 + {2'b0, dval};
  assign div_den = {1'b0, dval, 1'b0};

  heq_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    hist_q <= hist[idx];
    lut_q <= lut[idx];
    div_start <= !rst && (state == ST_BLD_CALC) && !ident && (nval < dval);
    if (rst) begin
      state <= ST_CLEAR;
      idx <= '0;
      m_tvalid <= 1'b0;
      total <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          hist[idx] <= '0;
          lut[idx] <= idx;
          idx <= idx + 1'b1;
          if (idx == bin_t'(NumBins-1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            idx <= s_tdata;
            px <= s_tdata;
            last_q <= s_tlast;
            state <= (req_t'(s_tuser) == REQ_MAP) ? ST_MAP_RD : ST_ACC_RD;
          end
        end
        ST_ACC_RD: state <= ST_ACC_WR;
        ST_ACC_WR: begin
          if (hist_q != CountMax) hist[px] <= hist_q + 1'b1;
          if (total != CountMax) total <= total + 1'b1;
          if (last_q) begin
            idx <= '0;
            acc <= '0;
            found <= 1'b0;
            minv <= '0;
            state <= ST_SUM_RD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MAP_RD: state <= ST_OUT;
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= lut_q;
            m_tlast <= last_q;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        ST_SUM_RD: state <= ST_SUM;
        ST_SUM: begin
          if (!found && acc_sum != '0) begin
            found <= 1'b1;
            minv <= acc_sum[CountWidth-1:0];
          end
          idx <= idx + 1'b1;
          if (idx == bin_t'(NumBins-1)) begin
            acc <= '0;
            ident <= ((found ? minv : acc_sum[CountWidth-1:0]) == total);
            state <= ST_BLD_RD;
          end else begin
            acc <= acc_sum;
            state <= ST_SUM_RD;
          end
        end
        ST_BLD_RD: state <= ST_BLD_CALC;
        ST_BLD_CALC: begin
          if (ident) begin
            acc <= acc_sum;
            lut[idx] <= idx;
            idx <= idx + 1'b1;
            state <= (idx == bin_t'(NumBins-1)) ? ST_WIPE : ST_BLD_RD;
          end else if (nval >= dval) begin
            acc <= acc_sum;
            lut[idx] <= 8'd255;
            idx <= idx + 1'b1;
            state <= (idx == bin_t'(NumBins-1)) ? ST_WIPE : ST_BLD_RD;
          end else begin
            state <= ST_BLD_DIV;
          end
        end
        ST_BLD_DIV: begin
          if (div_done) begin
            acc <= acc_sum;
            lut[idx] <= div_q[7:0];
            idx <= idx + 1'b1;
            state <= (idx == bin_t'(NumBins-1)) ? ST_WIPE : ST_BLD_RD;
          end
        end
        ST_WIPE: begin
          hist[idx] <= '0;
          total <= '0;
          idx <= idx + 1'b1;
          if (idx == bin_t'(NumBins-1)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "histogram_equalizer_8bit_assert.svh"
  `HEQ_ASSERT_IMPL(a_ready_idle_only, s_tready, !m_tvalid, "ready while output pending")
  `HEQ_ASSERT_NEXT(a_map_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                   "output dropped")
  `HEQ_ASSERT_NEXT(a_div_one_start, div_start, !div_start, "double divider start")
endmodule
